### hdl/cpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared types, constants and the arctangent table of the phase-angle pipeline.
// ----------------------------------------------------------------------------
package cpa_pkg;

  localparam int FIELD_W          = 16;  // width of the sample and angle ports
  localparam int GUARD_BITS       = 8;
  localparam int TABLE_LEN        = 24;
  localparam int Z_W              = 33;  // angle accumulator, 29 fraction bits
  localparam int ROUND_SHIFT      = 16;  // Q29 down to Q13
  localparam int ITERATIONS_DEF   = 16;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam int PI_Q13      = 25736;
  localparam int HALF_PI_Q13 = 12868;
  localparam int HALF_PI_Q29 = 843314857;
  localparam int ROUND_HALF  = 32768;

  typedef logic signed [FIELD_W-1:0] angle_t;

  typedef struct packed {
    logic   valid;
    logic   bypass;
    angle_t bypass_angle;
  } cpa_ctrl_t;

  // atan(2^-i) in radians, scaled by 2^29
  function automatic logic signed [Z_W-1:0] atan_q29(input int idx);
    int v;
    begin
      case (idx)
        0:  v = 421657428;
        1:  v = 248918915;
        2:  v = 131521918;
        3:  v = 66762579;
        4:  v = 33510843;
        5:  v = 16771758;
        6:  v = 8387925;
        7:  v = 4194219;
        8:  v = 2097141;
        9:  v = 1048575;
        10: v = 524288;
        11: v = 262144;
        12: v = 131072;
        13: v = 65536;
        14: v = 32768;
        15: v = 16384;
        16: v = 8192;
        17: v = 4096;
        18: v = 2048;
        19: v = 1024;
        20: v = 512;
        21: v = 256;
        22: v = 128;
        23: v = 64;
        default: v = 0;
      endcase
      atan_q29 = Z_W'(v);
    end
  endfunction

endpackage
`default_nettype wire

### hdl/cpa_prep.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpa_prep
// Entry stage: widens the sample, spots the special cases and folds the
// left half plane into the right by a quarter turn.
// ----------------------------------------------------------------------------
module cpa_prep import cpa_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int CW           = SAMPLE_WIDTH_DEF + GUARD_BITS + 3
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     req,
  input  wire  [FIELD_W-1:0]      real_part,
  input  wire  [FIELD_W-1:0]      imag_part,
  output logic signed [CW-1:0]    x_o,
  output logic signed [CW-1:0]    y_o,
  output logic signed [Z_W-1:0]   z_o,
  output cpa_ctrl_t               ctrl_o
);

  logic signed [CW-1:0]  re_w;
  logic signed [CW-1:0]  im_w;
  logic signed [CW-1:0]  x_f;
  logic signed [CW-1:0]  y_f;
  logic signed [CW-1:0]  x_nxt;
  logic signed [CW-1:0]  y_nxt;
  logic signed [Z_W-1:0] z_nxt;
  cpa_ctrl_t             ctrl_nxt;
  logic signed [CW-1:0]  x_r;
  logic signed [CW-1:0]  y_r;
  logic signed [Z_W-1:0] z_r;
  cpa_ctrl_t             ctrl_r;
  logic                  re_zero;
  logic                  im_zero;

  // narrow samples are sign-extended; wider settings see the port as unsigned
  generate
    if (SAMPLE_WIDTH <= FIELD_W) begin : g_narrow
      assign re_w = {{(CW-SAMPLE_WIDTH){real_part[SAMPLE_WIDTH-1]}},
                     real_part[SAMPLE_WIDTH-1:0]};
      assign im_w = {{(CW-SAMPLE_WIDTH){imag_part[SAMPLE_WIDTH-1]}},
                     imag_part[SAMPLE_WIDTH-1:0]};
    end else begin : g_wide
      assign re_w = {{(CW-FIELD_W){1'b0}}, real_part};
      assign im_w = {{(CW-FIELD_W){1'b0}}, imag_part};
    end
  endgenerate

  assign re_zero = (re_w == '0);
  assign im_zero = (im_w == '0);

  always_comb begin
    x_f   = re_w;
    y_f   = im_w;
    z_nxt = '0;
    if (re_w[CW-1]) begin
      if (!im_w[CW-1]) begin
        x_f   = im_w;
        y_f   = -re_w;
        z_nxt = Z_W'(HALF_PI_Q29);
      end else begin
        x_f   = -im_w;
        y_f   = re_w;
        z_nxt = -Z_W'(HALF_PI_Q29);
      end
    end
    x_nxt = x_f <<< GUARD_BITS;
    y_nxt = y_f <<< GUARD_BITS;
  end

  always_comb begin
    ctrl_nxt.valid        = req;
    ctrl_nxt.bypass       = re_zero || im_zero;
    ctrl_nxt.bypass_angle = '0;
    if (re_zero && !im_zero) begin
      ctrl_nxt.bypass_angle = im_w[CW-1] ? -FIELD_W'(HALF_PI_Q13) : FIELD_W'(HALF_PI_Q13);
    end else if (im_zero && re_w[CW-1]) begin
      ctrl_nxt.bypass_angle = FIELD_W'(PI_Q13);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign ctrl_o = ctrl_r;

endmodule
`default_nettype wire

### hdl/cpa_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpa_cell
// One CORDIC vectoring micro-rotation by atan(2^-SHIFT), registered.
// ----------------------------------------------------------------------------
module cpa_cell import cpa_pkg::*; #(
  parameter int CW    = SAMPLE_WIDTH_DEF + GUARD_BITS + 3,
  parameter int SHIFT = 0
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire  signed [CW-1:0]    x_i,
  input  wire  signed [CW-1:0]    y_i,
  input  wire  signed [Z_W-1:0]   z_i,
  input  cpa_ctrl_t               ctrl_i,
  output logic signed [CW-1:0]    x_o,
  output logic signed [CW-1:0]    y_o,
  output logic signed [Z_W-1:0]   z_o,
  output cpa_ctrl_t               ctrl_o
);

  localparam logic signed [Z_W-1:0] ATAN_STEP = atan_q29(SHIFT);

  logic signed [CW-1:0]  xs;
  logic signed [CW-1:0]  ys;
  logic signed [CW-1:0]  x_nxt;
  logic signed [CW-1:0]  y_nxt;
  logic signed [Z_W-1:0] z_nxt;
  logic signed [CW-1:0]  x_r;
  logic signed [CW-1:0]  y_r;
  logic signed [Z_W-1:0] z_r;
  cpa_ctrl_t             ctrl_r;

  assign xs = x_i >>> SHIFT;
  assign ys = y_i >>> SHIFT;

  // rotate towards the real axis
  always_comb begin
    if (!y_i[CW-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ATAN_STEP;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ATAN_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign ctrl_o = ctrl_r;

endmodule
`default_nettype wire

### hdl/cpa_post.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpa_post
// Exit stage: rounds the accumulated angle to Q3.13, saturates to +-pi and
// selects the special-case angle where one was flagged.
// ----------------------------------------------------------------------------
module cpa_post import cpa_pkg::*; (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire  signed [Z_W-1:0]   z_i,
  input  cpa_ctrl_t               ctrl_i,
  output logic                    valid_o,
  output angle_t                  angle_o
);

  localparam int RW = Z_W - ROUND_SHIFT;
  localparam logic signed [RW-1:0] PI_R  = RW'(PI_Q13);
  localparam logic signed [RW-1:0] NPI_R = -RW'(PI_Q13);

  logic signed [Z_W-1:0] z_rnd;
  logic signed [RW-1:0]  res;
  angle_t                angle_nxt;
  angle_t                angle_r;
  logic                  valid_r;

  assign z_rnd = z_i + Z_W'(ROUND_HALF);
  assign res   = z_rnd[Z_W-1:ROUND_SHIFT];

  always_comb begin
    if (ctrl_i.bypass) begin
      angle_nxt = ctrl_i.bypass_angle;
    end else if (res > PI_R) begin
      angle_nxt = FIELD_W'(PI_Q13);
    end else if (res < NPI_R) begin
      angle_nxt = -FIELD_W'(PI_Q13);
    end else begin
      angle_nxt = res[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    angle_r <= angle_nxt;
  end

  assign valid_o = valid_r;
  assign angle_o = angle_r;

endmodule
`default_nettype wire

### hdl/complex_phase_angle.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// complex_phase_angle
// Four-quadrant phase angle atan2(im, re) of a complex sample, Q3.13 radians.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_real_part / in_imag_part and raise start; the request is taken
//   at every rising edge with start high and busy low. busy is always low,
//   so a new sample may be issued in every cycle.
//   Each result appears on out_angle for exactly one cycle, marked by
//   out_valid, and must be taken then: there is no way to hold it off.
//   A sample passes through registered stages, with N = min(ITERATIONS, 24):
//   one entry stage that folds the sample into the right half plane, one
//   cell per micro-rotation, and one exit stage that rounds and saturates.
//   Throughput is one sample per cycle, set by the row of cells, each doing
//   a single micro-rotation.
//   Results leave in request order.
//   Synchronous reset (rst_n low) empties the pipeline: requests in flight
//   are dropped and no strobe follows until new requests arrive.
// ----------------------------------------------------------------------------
module complex_phase_angle import cpa_pkg::*; #(
  parameter int ITERATIONS   = ITERATIONS_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  wire  [FIELD_W-1:0]  in_real_part,
  input  wire  [FIELD_W-1:0]  in_imag_part,
  output logic                out_valid,
  output logic [FIELD_W-1:0]  out_angle
);

  localparam int N  = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;
  localparam int CW = SAMPLE_WIDTH + GUARD_BITS + 3;
  localparam int LATENCY = N + 2;

  logic signed [CW-1:0]  x_s [0:N];
  logic signed [CW-1:0]  y_s [0:N];
  logic signed [Z_W-1:0] z_s [0:N];
  cpa_ctrl_t             ctrl_s [0:N];
  angle_t                angle_w;

  assign busy = 1'b0;

  cpa_prep #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .CW           (CW)
  ) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (start && !busy),
    .real_part (in_real_part),
    .imag_part (in_imag_part),
    .x_o       (x_s[0]),
    .y_o       (y_s[0]),
    .z_o       (z_s[0]),
    .ctrl_o    (ctrl_s[0])
  );

  generate
    for (genvar k = 0; k < N; k++) begin : g_cell
      cpa_cell #(
        .CW    (CW),
        .SHIFT (k)
      ) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .x_i    (x_s[k]),
        .y_i    (y_s[k]),
        .z_i    (z_s[k]),
        .ctrl_i (ctrl_s[k]),
        .x_o    (x_s[k+1]),
        .y_o    (y_s[k+1]),
        .z_o    (z_s[k+1]),
        .ctrl_o (ctrl_s[k+1])
      );
    end
  endgenerate

  cpa_post u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .z_i     (z_s[N]),
    .ctrl_i  (ctrl_s[N]),
    .valid_o (out_valid),
    .angle_o (angle_w)
  );

  assign out_angle = angle_w;

  // every request yields a matching result strobe
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("request did not produce a result at the expected latency");

  // no strobe without a matching request
  a_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a request");

  // a zero sample gives a zero angle
  a_zero_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(start && (in_real_part == '0) && (in_imag_part == '0), LATENCY))
      |-> (out_angle == '0))
    else $error("zero sample gave a nonzero angle");

endmodule
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the phase-angle pipeline against a bit-exact CORDIC vectoring model.
// Samples are sent with random gaps; every strobed angle is compared in order
// with the angle predicted for the oldest outstanding request.
// ----------------------------------------------------------------------------
module testbench;
  import cpa_pkg::FIELD_W;
  import cpa_pkg::angle_t;

  localparam int     ROTATIONS   = 16;           // default ITERATIONS, below the table length
  localparam int     SHIFT_GUARD = 8;
  localparam longint ANGLE_PI    = 25736;
  localparam longint ANGLE_HALF  = 12868;
  localparam longint HALF_TURN_Z = 843314857;    // pi/2 with 29 fraction bits
  localparam longint ROUND_BIAS  = 32768;
  localparam int     Z_TO_Q13    = 16;
  localparam int     LATENCY     = ROTATIONS + 2;
  localparam int     CYCLE_LIMIT = 400000;
  localparam int     REPORT_MAX  = 10;

  typedef struct {
    logic signed [FIELD_W-1:0] re;
    logic signed [FIELD_W-1:0] im;
    angle_t                    angle;
  } phase_req_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic [FIELD_W-1:0]  in_real_part = '0;
  logic [FIELD_W-1:0]  in_imag_part = '0;
  wire                 busy;
  wire                 out_valid;
  wire  [FIELD_W-1:0]  out_angle;

  longint     arctan_z [0:23];
  phase_req_t pending_angles [$];
  int         mismatches = 0;
  int         cycle_count = 0;
  bit         no_idle = 1'b0;

  complex_phase_angle dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_real_part (in_real_part),
    .in_imag_part (in_imag_part),
    .out_valid    (out_valid),
    .out_angle    (out_angle)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic angle_t phase_of(input logic signed [FIELD_W-1:0] re_in,
                                      input logic signed [FIELD_W-1:0] im_in);
    longint x;
    longint y;
    longint z;
    longint t;
    longint xs;
    longint ys;
    longint res;
    x = longint'(re_in);
    y = longint'(im_in);
    z = 0;
    if (x == 0 && y == 0) begin
      res = 0;
    end else if (x == 0) begin
      res = (y > 0) ? ANGLE_HALF : -ANGLE_HALF;
    end else if (y == 0) begin
      res = (x < 0) ? ANGLE_PI : 0;
    end else begin
      // fold the left half plane over by a quarter turn
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y;
          y = -t;
          z = HALF_TURN_Z;
        end else begin
          x = -y;
          y = t;
          z = -HALF_TURN_Z;
        end
      end
      x = x <<< SHIFT_GUARD;
      y = y <<< SHIFT_GUARD;
      for (int i = 0; i < ROTATIONS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + arctan_z[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - arctan_z[i];
        end
      end
      res = (z + ROUND_BIAS) >>> Z_TO_Q13;
      if (res > ANGLE_PI) res = ANGLE_PI;
      if (res < -ANGLE_PI) res = -ANGLE_PI;
    end
    return angle_t'(res);
  endfunction

  // Mostly short gaps, now and then a long one; none while no_idle is set.
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [FIELD_W-1:0] near_zero(input int span);
    int v;
    v = $urandom_range(0, 2 * span) - span;
    return FIELD_W'(v);
  endfunction

  // Called at a rising edge; waits for the edge that takes the request, then idles for a random gap.
  task automatic send_sample(input logic signed [FIELD_W-1:0] re,
                             input logic signed [FIELD_W-1:0] im);
    phase_req_t req;
    int         gap;
    req.re    = re;
    req.im    = im;
    req.angle = phase_of(re, im);
    start        <= 1'b1;
    in_real_part <= re;
    in_imag_part <= im;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    pending_angles.push_back(req);
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
  endtask

  // Results are sampled mid-cycle, where the strobe and the angle are settled.
  always @(negedge clk) begin
    phase_req_t req;
    if (rst_n && out_valid) begin
      if (pending_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected angle %0d with no request outstanding",
                   $signed(out_angle));
      end else begin
        req = pending_angles.pop_front();
        if (out_angle !== req.angle) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("angle mismatch re=%0d im=%0d: expected %0d, got %0d",
                     req.re, req.im, req.angle, $signed(out_angle));
        end
      end
    end
  end

  task automatic test_directed();
    send_sample(0, 0);
    send_sample(0, 1);
    send_sample(0, -1);
    send_sample(0, 16'sh7fff);
    send_sample(0, -16'sh8000);
    send_sample(1, 0);
    send_sample(-1, 0);
    send_sample(16'sh7fff, 0);
    send_sample(-16'sh8000, 0);
    send_sample(1, 1);
    send_sample(1, -1);
    send_sample(-1, 1);
    send_sample(-1, -1);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(-16'sh8000, -16'sh8000);
    send_sample(-16'sh8000, 16'sh7fff);
    send_sample(16'sh7fff, -16'sh8000);
    // just either side of the negative real axis, where rounding may pass pi, and of the positive real axis
    send_sample(-16'sh8000, 1);
    send_sample(-16'sh8000, -1);
    send_sample(-16'sh7fff, 1);
    send_sample(-16'sh7fff, -1);
    send_sample(16'sh7fff, 1);
    send_sample(16'sh7fff, -1);
  endtask

  task automatic test_uniform();
    logic signed [FIELD_W-1:0] re;
    logic signed [FIELD_W-1:0] im;
    for (int n = 0; n < 1000; n++) begin
      // hold a few stretches back to back
      if (n % 250 == 0) no_idle = ~no_idle;
      re = FIELD_W'($urandom);
      im = FIELD_W'($urandom);
      send_sample(re, im);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_near_axes();
    logic signed [FIELD_W-1:0] re;
    logic signed [FIELD_W-1:0] im;
    for (int n = 0; n < 400; n++) begin
      case ($urandom_range(0, 3))
        0: begin re = near_zero(4); im = near_zero(4); end
        1: begin re = near_zero(2); im = FIELD_W'($urandom); end
        2: begin re = FIELD_W'($urandom); im = near_zero(2); end
        default: begin re = near_zero(64); im = near_zero(64); end
      endcase
      send_sample(re, im);
    end
  endtask

  task automatic test_pi_boundary();
    logic signed [FIELD_W-1:0] re;
    logic signed [FIELD_W-1:0] im;
    for (int n = 0; n < 350; n++) begin
      re = FIELD_W'(-$signed({1'b0, 15'($urandom)}) - 1);
      im = (n % 4 == 0) ? FIELD_W'($urandom) : near_zero(3);
      send_sample(re, im);
    end
  endtask

  initial begin
    arctan_z = '{421657428, 248918915, 131521918, 66762579,
                 33510843, 16771758, 8387925, 4194219,
                 2097141, 1048575, 524288, 262144,
                 131072, 65536, 32768, 16384,
                 8192, 4096, 2048, 1024,
                 512, 256, 128, 64};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    drain_results();
    test_uniform();
    drain_results();
    test_near_axes();
    test_pi_boundary();
    drain_results();

    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0 && pending_angles.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
